// ===== hdl/kbs_pkg.sv =====
// kbs_pkg: shared constants for the keyframe bracket search block
// depends on nothing

package kbs_pkg;

    localparam int MAX_KEYFRAMES_DEF    = 64;
    localparam int MAX_SLOTS_DEF        = 64;
    localparam int BONE_ID_BITS_DEF     = 8;
    localparam int WEIGHT_FRAC_BITS_DEF = 16;

    localparam int ACTION_W   = 2;
    localparam int INTERVAL_W = 32;
    localparam int BONE_W     = 8;
    localparam int TIME_W     = 32;
    localparam int STATUS_W   = 2;
    localparam int IDX_W      = 6;
    localparam int WEIGHT_W   = 17;

    localparam logic [ACTION_W-1:0] ACT_APPEND_KF   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_APPEND_SLOT = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_QUERY       = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_CLEAR       = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

    typedef logic [ACTION_W-1:0] action_t;
    typedef logic [STATUS_W-1:0] status_t;

endpackage

// ===== hdl/kbs_ram.sv =====
// kbs_ram: generic single write port memory with registered read
// depends on nothing

module kbs_ram #(
    parameter int W = 8,
    parameter int D = 64
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
    input  logic [W-1:0]                         wdata,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
    output logic [W-1:0]                         rdata
);

    logic [W-1:0] mem [D];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/kbs_div.sv =====
// kbs_div: restoring divider, one quotient bit per cycle, numerator below denominator
// depends on nothing

module kbs_div #(
    parameter int NW = 39,
    parameter int QW = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          go,
    input  logic [NW-1:0] num,
    input  logic [NW-1:0] den,
    output logic          fin,
    output logic [QW-1:0] quo
);

    localparam int CW = $clog2(QW + 1);

    logic [NW:0]   rem_reg, rem_next;
    logic [NW-1:0] den_reg, den_next;
    logic [QW-1:0] quo_reg, quo_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          run_reg, run_next;
    logic          fin_reg, fin_next;
    logic [NW:0]   dbl;

    always_comb
    begin
        rem_next = rem_reg;
        den_next = den_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        run_next = run_reg;
        fin_next = 1'b0;
        dbl      = {rem_reg[NW-1:0], 1'b0};
        if (go)
        begin
            rem_next = {1'b0, num};
            den_next = den;
            quo_next = '0;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (dbl >= {1'b0, den_reg})
            begin
                rem_next = dbl - {1'b0, den_reg};
                quo_next = {quo_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next = dbl;
                quo_next = {quo_reg[QW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(QW - 1))
            begin
                run_next = 1'b0;
                fin_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            fin_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            fin_reg <= fin_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign fin = fin_reg;
    assign quo = quo_reg;

endmodule

// ===== hdl/keyframe_bracket_search.sv =====
// keyframe_bracket_search: top level, keyframe table memories and the query walk
// depends on kbs_pkg, kbs_ram, kbs_div

// Append keyframe, append bone slot and clear answer in the cycle after start.
// A query reads each keyframe entry (states S_KF and S_KFD), then streams that
// keyframe's bone slots from the bone memory one per cycle until a match or the
// last slot; then S_RES picks the bracket and, when the time lies at or after
// the left keyframe and before the right one, the serial divider computes the
// weight. busy is high while a query is in work; done pulses for one cycle
// with the result, which the receiver must take in that cycle.

module keyframe_bracket_search #(
    parameter int MAX_KEYFRAMES    = kbs_pkg::MAX_KEYFRAMES_DEF,
    parameter int MAX_SLOTS        = kbs_pkg::MAX_SLOTS_DEF,
    parameter int BONE_ID_BITS     = kbs_pkg::BONE_ID_BITS_DEF,
    parameter int WEIGHT_FRAC_BITS = kbs_pkg::WEIGHT_FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  kbs_pkg::action_t                   action,
    input  logic [kbs_pkg::INTERVAL_W-1:0]     interval,
    input  logic [kbs_pkg::BONE_W-1:0]         bone_id,
    input  logic [kbs_pkg::TIME_W-1:0]         query_time,
    output logic                               done,
    output kbs_pkg::status_t                   status,
    output logic [kbs_pkg::IDX_W-1:0]          left_keyframe,
    output logic [kbs_pkg::IDX_W-1:0]          left_slot,
    output logic [kbs_pkg::IDX_W-1:0]          right_keyframe,
    output logic [kbs_pkg::IDX_W-1:0]          right_slot,
    output logic [kbs_pkg::WEIGHT_W-1:0]       blend_weight
);

    import kbs_pkg::*;

    localparam int KW   = (MAX_KEYFRAMES > 1) ? $clog2(MAX_KEYFRAMES) : 1;
    localparam int CNTW = $clog2(MAX_KEYFRAMES + 1);
    localparam int SW   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int SCW  = $clog2(MAX_SLOTS + 1);
    localparam int BD   = MAX_KEYFRAMES * MAX_SLOTS;
    localparam int BAW  = (BD > 1) ? $clog2(BD) : 1;
    localparam int TLW  = INTERVAL_W + CNTW;
    localparam int TRW  = TLW + 1;
    localparam int WW   = WEIGHT_FRAC_BITS + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_KF   = 3'd1;
    localparam logic [2:0] S_KFD  = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_RES  = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;

    logic [2:0]              state_reg, state_next;
    logic [CNTW-1:0]         count_reg, count_next;
    logic [TLW-1:0]          total_reg, total_next;
    logic [SCW-1:0]          newest_reg, newest_next;
    logic [BONE_ID_BITS-1:0] id_reg, id_next;
    logic [TIME_W-1:0]       t_reg, t_next;
    logic [CNTW-1:0]         k_reg, k_next;
    logic [TLW-1:0]          acc_reg, acc_next;
    logic [SCW-1:0]          cnt_reg, cnt_next;
    logic [INTERVAL_W-1:0]   ival_reg, ival_next;
    logic [SCW-1:0]          s_reg, s_next;
    logic                    pend_reg, pend_next;
    logic [SW-1:0]           pend_s_reg, pend_s_next;

    logic                    first_v_reg, first_v_next;
    logic [KW-1:0]           first_k_reg, first_k_next;
    logic [SW-1:0]           first_s_reg, first_s_next;
    logic [TLW-1:0]          first_st_reg, first_st_next;
    logic [KW-1:0]           last_k_reg, last_k_next;
    logic [SW-1:0]           last_s_reg, last_s_next;
    logic [TLW-1:0]          last_st_reg, last_st_next;
    logic                    bef_v_reg, bef_v_next;
    logic [KW-1:0]           bef_k_reg, bef_k_next;
    logic [SW-1:0]           bef_s_reg, bef_s_next;
    logic [TLW-1:0]          bef_st_reg, bef_st_next;
    logic                    aft_v_reg, aft_v_next;
    logic [KW-1:0]           aft_k_reg, aft_k_next;
    logic [SW-1:0]           aft_s_reg, aft_s_next;
    logic [TLW-1:0]          aft_st_reg, aft_st_next;

    logic                    done_reg, done_next;
    status_t                 status_reg, status_next;
    logic [IDX_W-1:0]        lk_reg, lk_next;
    logic [IDX_W-1:0]        ls_reg, ls_next;
    logic [IDX_W-1:0]        rk_reg, rk_next;
    logic [IDX_W-1:0]        rs_reg, rs_next;
    logic [WEIGHT_W-1:0]     w_reg, w_next;

    logic                    iv_we;
    logic [KW-1:0]           iv_waddr;
    logic [KW-1:0]           kf_raddr;
    logic [INTERVAL_W-1:0]   iv_rdata;
    logic                    sc_we;
    logic [KW-1:0]           sc_waddr;
    logic [SCW-1:0]          sc_wdata;
    logic [SCW-1:0]          sc_rdata;
    logic                    bn_we;
    logic [BAW-1:0]          bn_waddr;
    logic [BAW-1:0]          bn_raddr;
    logic [BONE_ID_BITS-1:0] bn_rdata;

    logic                    div_go;
    logic [TRW-1:0]          div_num;
    logic [TRW-1:0]          div_den;
    logic                    div_fin;
    logic [WEIGHT_FRAC_BITS-1:0] div_quo;

    logic [KW-1:0]           sel_lk, sel_rk;
    logic [SW-1:0]           sel_ls, sel_rs;
    logic [TRW-1:0]          tl, tr;
    logic [TRW-1:0]          tq;
    logic                    hit;
    logic [KW-1:0]           last_kf;

    kbs_ram #(.W(INTERVAL_W), .D(MAX_KEYFRAMES)) u_iv_ram (
        .clk   (clk),
        .we    (iv_we),
        .waddr (iv_waddr),
        .wdata (interval),
        .raddr (kf_raddr),
        .rdata (iv_rdata)
    );

    kbs_ram #(.W(SCW), .D(MAX_KEYFRAMES)) u_sc_ram (
        .clk   (clk),
        .we    (sc_we),
        .waddr (sc_waddr),
        .wdata (sc_wdata),
        .raddr (kf_raddr),
        .rdata (sc_rdata)
    );

    kbs_ram #(.W(BONE_ID_BITS), .D(BD)) u_bone_ram (
        .clk   (clk),
        .we    (bn_we),
        .waddr (bn_waddr),
        .wdata (BONE_ID_BITS'(bone_id)),
        .raddr (bn_raddr),
        .rdata (bn_rdata)
    );

    kbs_div #(.NW(TRW), .QW(WEIGHT_FRAC_BITS)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (div_go),
        .num   (div_num),
        .den   (div_den),
        .fin   (div_fin),
        .quo   (div_quo)
    );

    assign last_kf  = KW'(count_reg - 1'b1);
    assign kf_raddr = k_reg[KW-1:0];
    assign bn_raddr = BAW'(k_reg[KW-1:0]) * BAW'(MAX_SLOTS) + BAW'(s_reg);
    assign hit      = pend_reg && (bn_rdata == id_reg);
    assign tq       = TRW'(t_reg);

    // bracket selection from the recorded hits
    always_comb
    begin
        tl = TRW'(last_st_reg);
        tr = tl;
        sel_lk = last_k_reg;
        sel_ls = last_s_reg;
        sel_rk = last_k_reg;
        sel_rs = last_s_reg;
        if (bef_v_reg)
        begin
            sel_lk = bef_k_reg;
            sel_ls = bef_s_reg;
            sel_rk = bef_k_reg;
            sel_rs = bef_s_reg;
            tl = TRW'(bef_st_reg);
            tr = tl;
            if (aft_v_reg)
            begin
                sel_rk = aft_k_reg;
                sel_rs = aft_s_reg;
                tr = TRW'(aft_st_reg);
            end
            else if (first_k_reg != bef_k_reg)
            begin
                sel_rk = first_k_reg;
                sel_rs = first_s_reg;
                tr = TRW'(total_reg) + TRW'(first_st_reg);
            end
        end
        else if (first_k_reg != last_k_reg)
        begin
            sel_rk = first_k_reg;
            sel_rs = first_s_reg;
            tr = TRW'(total_reg) + TRW'(first_st_reg);
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        total_next    = total_reg;
        newest_next   = newest_reg;
        id_next       = id_reg;
        t_next        = t_reg;
        k_next        = k_reg;
        acc_next      = acc_reg;
        cnt_next      = cnt_reg;
        ival_next     = ival_reg;
        s_next        = s_reg;
        pend_next     = 1'b0;
        pend_s_next   = pend_s_reg;
        first_v_next  = first_v_reg;
        first_k_next  = first_k_reg;
        first_s_next  = first_s_reg;
        first_st_next = first_st_reg;
        last_k_next   = last_k_reg;
        last_s_next   = last_s_reg;
        last_st_next  = last_st_reg;
        bef_v_next    = bef_v_reg;
        bef_k_next    = bef_k_reg;
        bef_s_next    = bef_s_reg;
        bef_st_next   = bef_st_reg;
        aft_v_next    = aft_v_reg;
        aft_k_next    = aft_k_reg;
        aft_s_next    = aft_s_reg;
        aft_st_next   = aft_st_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        lk_next       = lk_reg;
        ls_next       = ls_reg;
        rk_next       = rk_reg;
        rs_next       = rs_reg;
        w_next        = w_reg;
        iv_we         = 1'b0;
        iv_waddr      = count_reg[KW-1:0];
        sc_we         = 1'b0;
        sc_waddr      = count_reg[KW-1:0];
        sc_wdata      = '0;
        bn_we         = 1'b0;
        bn_waddr      = BAW'(last_kf) * BAW'(MAX_SLOTS) + BAW'(newest_reg);
        div_go        = 1'b0;
        div_num       = tq - tl;
        div_den       = tr - tl;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    done_next   = 1'b1;
                    status_next = ST_OK;
                    lk_next     = '0;
                    ls_next     = '0;
                    rk_next     = '0;
                    rs_next     = '0;
                    w_next      = '0;
                    unique case (action)
                        ACT_APPEND_KF:
                        begin
                            if (count_reg >= CNTW'(MAX_KEYFRAMES))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                iv_we       = 1'b1;
                                sc_we       = 1'b1;
                                total_next  = total_reg + TLW'(interval);
                                lk_next     = IDX_W'(count_reg);
                                count_next  = count_reg + 1'b1;
                                newest_next = '0;
                            end
                        end
                        ACT_APPEND_SLOT:
                        begin
                            if (count_reg == '0 || newest_reg >= SCW'(MAX_SLOTS))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                bn_we       = 1'b1;
                                sc_we       = 1'b1;
                                sc_waddr    = last_kf;
                                sc_wdata    = newest_reg + 1'b1;
                                newest_next = newest_reg + 1'b1;
                                lk_next     = IDX_W'(last_kf);
                                ls_next     = IDX_W'(newest_reg);
                            end
                        end
                        ACT_QUERY:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                done_next   = 1'b0;
                                id_next     = BONE_ID_BITS'(bone_id);
                                t_next      = query_time;
                                k_next      = '0;
                                acc_next    = '0;
                                first_v_next = 1'b0;
                                bef_v_next  = 1'b0;
                                aft_v_next  = 1'b0;
                                state_next  = S_KF;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            count_next  = '0;
                            total_next  = '0;
                            newest_next = '0;
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_KF:
            begin
                state_next = S_KFD;
            end
            S_KFD:
            begin
                cnt_next  = sc_rdata;
                ival_next = iv_rdata;
                s_next    = '0;
                if (sc_rdata == '0)
                begin
                    acc_next = acc_reg + TLW'(iv_rdata);
                    k_next   = k_reg + 1'b1;
                    state_next = (k_reg + 1'b1 == count_reg) ? S_RES : S_KF;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (hit || (pend_reg && SCW'(pend_s_reg) + 1'b1 == cnt_reg))
                begin
                    if (hit)
                    begin
                        if (!first_v_reg)
                        begin
                            first_v_next  = 1'b1;
                            first_k_next  = k_reg[KW-1:0];
                            first_s_next  = pend_s_reg;
                            first_st_next = acc_reg;
                        end
                        last_k_next  = k_reg[KW-1:0];
                        last_s_next  = pend_s_reg;
                        last_st_next = acc_reg;
                        if (acc_reg < TLW'(t_reg))
                        begin
                            bef_v_next  = 1'b1;
                            bef_k_next  = k_reg[KW-1:0];
                            bef_s_next  = pend_s_reg;
                            bef_st_next = acc_reg;
                        end
                        else if (!aft_v_reg)
                        begin
                            aft_v_next  = 1'b1;
                            aft_k_next  = k_reg[KW-1:0];
                            aft_s_next  = pend_s_reg;
                            aft_st_next = acc_reg;
                        end
                    end
                    acc_next   = acc_reg + TLW'(ival_reg);
                    k_next     = k_reg + 1'b1;
                    state_next = (k_reg + 1'b1 == count_reg) ? S_RES : S_KF;
                end
                else if (s_reg < cnt_reg)
                begin
                    pend_next   = 1'b1;
                    pend_s_next = s_reg[SW-1:0];
                    s_next      = s_reg + 1'b1;
                end
            end
            S_RES:
            begin
                lk_next    = IDX_W'(sel_lk);
                ls_next    = IDX_W'(sel_ls);
                rk_next    = IDX_W'(sel_rk);
                rs_next    = IDX_W'(sel_rs);
                status_next = ST_OK;
                w_next     = '0;
                state_next = S_IDLE;
                done_next  = 1'b1;
                if (!first_v_reg)
                begin
                    status_next = ST_NOT_FOUND;
                    lk_next = '0;
                    ls_next = '0;
                    rk_next = '0;
                    rs_next = '0;
                end
                else if (tl == tr || tq < tl)
                begin
                    w_next = '0;
                end
                else if (tq < tr)
                begin
                    div_go     = 1'b1;
                    done_next  = 1'b0;
                    state_next = S_DIV;
                end
                else
                begin
                    w_next = WEIGHT_W'(WW'(1) << WEIGHT_FRAC_BITS);
                end
            end
            S_DIV:
            begin
                if (div_fin)
                begin
                    w_next     = WEIGHT_W'(div_quo);
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            total_reg  <= '0;
            newest_reg <= '0;
            done_reg   <= 1'b0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            total_reg  <= total_next;
            newest_reg <= newest_next;
            done_reg   <= done_next;
            pend_reg   <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg       <= id_next;
        t_reg        <= t_next;
        k_reg        <= k_next;
        acc_reg      <= acc_next;
        cnt_reg      <= cnt_next;
        ival_reg     <= ival_next;
        s_reg        <= s_next;
        pend_s_reg   <= pend_s_next;
        first_v_reg  <= first_v_next;
        first_k_reg  <= first_k_next;
        first_s_reg  <= first_s_next;
        first_st_reg <= first_st_next;
        last_k_reg   <= last_k_next;
        last_s_reg   <= last_s_next;
        last_st_reg  <= last_st_next;
        bef_v_reg    <= bef_v_next;
        bef_k_reg    <= bef_k_next;
        bef_s_reg    <= bef_s_next;
        bef_st_reg   <= bef_st_next;
        aft_v_reg    <= aft_v_next;
        aft_k_reg    <= aft_k_next;
        aft_s_reg    <= aft_s_next;
        aft_st_reg   <= aft_st_next;
        status_reg   <= status_next;
        lk_reg       <= lk_next;
        ls_reg       <= ls_next;
        rk_reg       <= rk_next;
        rs_reg       <= rs_next;
        w_reg        <= w_next;
    end

    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign status         = status_reg;
    assign left_keyframe  = lk_reg;
    assign left_slot      = ls_reg;
    assign right_keyframe = rk_reg;
    assign right_slot     = rs_reg;
    assign blend_weight   = w_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNTW'(MAX_KEYFRAMES))
        else $error("keyframe count past table size");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result while still busy");

    a_accept_answers: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted request left unanswered");

    a_div_from_res: assert property (@(posedge clk) disable iff (!rst_n)
        div_go |-> (state_reg == S_RES))
        else $error("divider started outside bracket pick");

endmodule

// ===== sim/keyframe_bracket_search_tb.sv =====
// keyframe_bracket_search_tb: self-checking bench for the keyframe bracket search block
// builds keyframe tables, runs bracket queries and compares every result with a local predictor
// depends on kbs_pkg and keyframe_bracket_search
`timescale 1ns / 1ps

module keyframe_bracket_search_tb;
    import kbs_pkg::*;

    localparam int NKF = 64;
    localparam int NSL = 64;

    typedef struct packed {
        status_t     st;
        logic [5:0]  lk;
        logic [5:0]  ls;
        logic [5:0]  rk;
        logic [5:0]  rs;
        logic [16:0] w;
    } bracket_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    action_t     action;
    logic [31:0] interval;
    logic [7:0]  bone_id;
    logic [31:0] query_time;
    logic        done;
    status_t     status;
    logic [5:0]  left_keyframe;
    logic [5:0]  left_slot;
    logic [5:0]  right_keyframe;
    logic [5:0]  right_slot;
    logic [16:0] blend_weight;

    keyframe_bracket_search uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .action(action),
        .interval(interval), .bone_id(bone_id), .query_time(query_time), .done(done),
        .status(status), .left_keyframe(left_keyframe), .left_slot(left_slot),
        .right_keyframe(right_keyframe), .right_slot(right_slot),
        .blend_weight(blend_weight)
    );

    // predictor state
    logic [31:0] kf_interval [NKF];
    logic [7:0]  kf_bones    [NKF][NSL];
    int          kf_nslots   [NKF];
    int          kf_count;
    logic [37:0] anim_length;

    bracket_t expected_brackets[$];
    int       errors;
    int       idle_pct;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #400ms;
        $display("*** FAILED ***");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        errors++;
        $display("mismatch at %0t: %s", $time, msg);
    endtask

    function automatic int slot_holding(int k, logic [7:0] id);
        for (int s = 0; s < kf_nslots[k]; s++)
            if (kf_bones[k][s] == id)
                return s;
        return -1;
    endfunction

    function automatic bracket_t predict_bracket(action_t act, logic [31:0] ivl,
                                                 logic [7:0] id, logic [31:0] t);
        bracket_t r;
        logic [39:0] starts [NKF];
        int slots [NKF];
        logic [39:0] acc, tl, tr;
        logic [63:0] wt;
        int left, prior, right;
        r = '0;
        acc = '0;
        left = -1;
        prior = -1;
        right = -1;
        case (act)
            ACT_APPEND_KF:
            begin
                if (kf_count >= NKF)
                    r.st = ST_FULL;
                else
                begin
                    kf_interval[kf_count] = ivl;
                    kf_nslots[kf_count] = 0;
                    anim_length += ivl;
                    r.lk = 6'(kf_count);
                    kf_count++;
                end
            end
            ACT_APPEND_SLOT:
            begin
                if (kf_count == 0 || kf_nslots[kf_count-1] >= NSL)
                    r.st = ST_FULL;
                else
                begin
                    kf_bones[kf_count-1][kf_nslots[kf_count-1]] = id;
                    r.lk = 6'(kf_count - 1);
                    r.ls = 6'(kf_nslots[kf_count-1]);
                    kf_nslots[kf_count-1]++;
                end
            end
            ACT_QUERY:
            begin
                if (kf_count == 0)
                    r.st = ST_FULL;
                else
                begin
                    for (int k = 0; k < kf_count; k++)
                    begin
                        starts[k] = acc;
                        slots[k] = slot_holding(k, id);
                        if (slots[k] >= 0)
                        begin
                            left = k;
                            if (acc < 40'(t))
                                prior = k;
                        end
                        acc += 40'(kf_interval[k]);
                    end
                    if (prior >= 0)
                        left = prior;
                    if (left < 0)
                        r.st = ST_NOT_FOUND;
                    else
                    begin
                        tl = starts[left];
                        tr = tl;
                        for (int k = left + 1; k < kf_count && right < 0; k++)
                            if (slots[k] >= 0)
                            begin
                                right = k;
                                tr = starts[k];
                            end
                        for (int k = 0; k < left && right < 0; k++)
                            if (slots[k] >= 0)
                            begin
                                right = k;
                                tr = 40'(anim_length) + starts[k];
                            end
                        if (right < 0)
                            right = left;
                        if (tl == tr || 40'(t) < tl)
                            wt = 64'd0;
                        else if (40'(t) < tr)
                            wt = ((64'(t) - 64'(tl)) << 16) / (64'(tr) - 64'(tl));
                        else
                            wt = 64'd65536;
                        r.lk = 6'(left);
                        r.ls = 6'(slots[left]);
                        r.rk = 6'(right);
                        r.rs = 6'(slots[right]);
                        r.w = wt[16:0];
                    end
                end
            end
            default:
            begin
                kf_count = 0;
                anim_length = '0;
            end
        endcase
        return r;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_brackets.size() == 0)
                report_mismatch("result with no request pending");
            else
            begin
                bracket_t e;
                e = expected_brackets.pop_front();
                if (status !== e.st)
                    report_mismatch($sformatf("status %0d exp %0d", status, e.st));
                if (left_keyframe !== e.lk)
                    report_mismatch($sformatf("left_keyframe %0d exp %0d", left_keyframe, e.lk));
                if (left_slot !== e.ls)
                    report_mismatch($sformatf("left_slot %0d exp %0d", left_slot, e.ls));
                if (right_keyframe !== e.rk)
                    report_mismatch($sformatf("right_keyframe %0d exp %0d",
                                              right_keyframe, e.rk));
                if (right_slot !== e.rs)
                    report_mismatch($sformatf("right_slot %0d exp %0d", right_slot, e.rs));
                if (blend_weight !== e.w)
                    report_mismatch($sformatf("blend_weight %0d exp %0d", blend_weight, e.w));
            end
        end
    end

    task automatic send_request(action_t act, logic [31:0] ivl, logic [7:0] id,
                                logic [31:0] t);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        action <= act;
        interval <= ivl;
        bone_id <= id;
        query_time <= t;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_brackets.push_back(predict_bracket(act, ivl, id, t));
    endtask

    task automatic drain;
        start <= 1'b0;
        while (expected_brackets.size() != 0 || busy)
            @(posedge clk);
    endtask

    task automatic test_empty_table;
        send_request(ACT_QUERY, 32'd0, 8'd0, 32'd5);
        send_request(ACT_APPEND_SLOT, 32'd0, 8'd3, 32'd0);
        send_request(ACT_CLEAR, 32'd0, 8'd0, 32'd0);
    endtask

    task automatic test_directed_brackets;
        send_request(ACT_APPEND_KF, 32'd100, 8'd0, 32'd0);
        send_request(ACT_APPEND_SLOT, 32'd0, 8'd7, 32'd0);
        send_request(ACT_APPEND_SLOT, 32'd0, 8'd255, 32'd0);
        send_request(ACT_APPEND_SLOT, 32'd0, 8'd7, 32'd0);
        send_request(ACT_APPEND_KF, 32'd0, 8'd0, 32'd0);
        send_request(ACT_APPEND_SLOT, 32'd0, 8'd7, 32'd0);
        send_request(ACT_APPEND_KF, 32'hFFFF_FFFF, 8'd0, 32'd0);
        send_request(ACT_APPEND_SLOT, 32'd0, 8'd255, 32'd0);
        send_request(ACT_APPEND_SLOT, 32'd0, 8'd7, 32'd0);
        send_request(ACT_QUERY, 32'd0, 8'd7, 32'd0);
        send_request(ACT_QUERY, 32'd0, 8'd7, 32'd50);
        send_request(ACT_QUERY, 32'd0, 8'd7, 32'd100);
        send_request(ACT_QUERY, 32'd0, 8'd7, 32'd101);
        send_request(ACT_QUERY, 32'd0, 8'd255, 32'd99);
        send_request(ACT_QUERY, 32'd0, 8'd255, 32'hFFFF_FFFF);
        send_request(ACT_QUERY, 32'd0, 8'd42, 32'd10);
        send_request(ACT_CLEAR, 32'd0, 8'd0, 32'd0);
        send_request(ACT_QUERY, 32'd0, 8'd7, 32'd10);
    endtask

    // fill keyframe and slot capacity
    task automatic test_table_full;
        send_request(ACT_CLEAR, 32'd0, 8'd0, 32'd0);
        for (int k = 0; k < NKF; k++)
            send_request(ACT_APPEND_KF, $urandom_range(3), 8'd0, 32'd0);
        send_request(ACT_APPEND_KF, 32'd5, 8'd0, 32'd0);
        for (int s = 0; s <= NSL; s++)
            send_request(ACT_APPEND_SLOT, 32'd0, s[7:0], 32'd0);
        send_request(ACT_QUERY, 32'd0, 8'd63, 32'd1000);
        send_request(ACT_QUERY, 32'd0, 8'd200, 32'd1);
    endtask

    task automatic test_random_tables(int n_items);
        int sent;
        logic [31:0] t;
        sent = 0;
        while (sent < n_items)
        begin
            send_request(ACT_CLEAR, 32'd0, 8'd0, 32'd0);
            sent++;
            repeat ($urandom_range(1, 6))
            begin
                case ($urandom_range(3))
                    0: t = $urandom();
                    1: t = $urandom_range(0, 3);
                    default: t = $urandom_range(1, 1000);
                endcase
                send_request(ACT_APPEND_KF, t, 8'd0, 32'd0);
                repeat ($urandom_range(0, 4))
                begin
                    send_request(ACT_APPEND_SLOT, 32'd0,
                                 ($urandom_range(3) == 0) ? 8'($urandom()) : 8'($urandom_range(4)),
                                 32'd0);
                    sent++;
                end
                sent++;
            end
            repeat ($urandom_range(2, 6))
            begin
                t = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(0, 4000);
                send_request(ACT_QUERY, $urandom(),
                             ($urandom_range(4) == 0) ? 8'($urandom()) : 8'($urandom_range(4)), t);
                sent++;
            end
            if ($urandom_range(9) == 0)
            begin
                send_request(2'($urandom()), $urandom(), 8'($urandom()), $urandom());
                sent++;
            end
        end
    endtask

    initial
    begin
        errors = 0;
        idle_pct = 0;
        kf_count = 0;
        anim_length = '0;
        rst_n = 1'b0;
        start = 1'b0;
        action = ACT_CLEAR;
        interval = '0;
        bone_id = '0;
        query_time = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_table();
        test_directed_brackets();
        test_table_full();
        drain();
        idle_pct = 0;
        test_random_tables(6);
        idle_pct = 58;
        test_random_tables(6);
        idle_pct = 19;
        test_random_tables(6);
        idle_pct = 0;
        test_random_tables(6);
        drain();
        repeat (50) @(posedge clk);
        if (errors == 0 && expected_brackets.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
